### rtl/cda_pkg.sv
// Package for the calendar date advance core: microcode ROM, control word type,
// calendar helper functions (leap year, month length, mod 7).
// No dependencies.
`timescale 1ns / 1ps

package cda_pkg;

   // micro-ops
   localparam logic [2:0] OP_NOP     = 3'd0;
   localparam logic [2:0] OP_CAPTURE = 3'd1;
   localparam logic [2:0] OP_DELTA   = 3'd2;
   localparam logic [2:0] OP_ROLL    = 3'd3;
   localparam logic [2:0] OP_EMIT    = 3'd4;
   localparam logic [2:0] OP_LOAD    = 3'd5;

   // jump conditions; jump to target when true, else fall through
   localparam logic [2:0] COND_NEXT    = 3'd0;
   localparam logic [2:0] COND_ALWAYS  = 3'd1;
   localparam logic [2:0] COND_IDLE    = 3'd2;
   localparam logic [2:0] COND_KIND    = 3'd3;
   localparam logic [2:0] COND_NOT_FIT = 3'd4;
   localparam logic [2:0] COND_BUSY    = 3'd5;

   // program addresses
   localparam logic [2:0] STEP_WAIT  = 3'd0;
   localparam logic [2:0] STEP_DELTA = 3'd1;
   localparam logic [2:0] STEP_ROLL  = 3'd2;
   localparam logic [2:0] STEP_EMIT  = 3'd3;
   localparam logic [2:0] STEP_BACK  = 3'd4;
   localparam logic [2:0] STEP_LOAD  = 3'd5;

   localparam logic [8:0] YEAR_DAYS      = 9'd365;
   localparam logic [8:0] LEAP_YEAR_DAYS = 9'd366;
   localparam logic [3:0] LAST_MONTH     = 4'd11;

   typedef struct packed {
      logic [2:0] op;
      logic [2:0] cond;
      logic [2:0] target;
   } uword_type;

   function automatic uword_type ucode_rom(input logic [2:0] step);
      uword_type w;
      unique case (step)
         STEP_WAIT:  w = '{op: OP_CAPTURE, cond: COND_IDLE,    target: STEP_WAIT};
         STEP_DELTA: w = '{op: OP_DELTA,   cond: COND_KIND,    target: STEP_LOAD};
         STEP_ROLL:  w = '{op: OP_ROLL,    cond: COND_NOT_FIT, target: STEP_ROLL};
         STEP_EMIT:  w = '{op: OP_EMIT,    cond: COND_BUSY,    target: STEP_EMIT};
         STEP_BACK:  w = '{op: OP_NOP,     cond: COND_ALWAYS,  target: STEP_WAIT};
         STEP_LOAD:  w = '{op: OP_LOAD,    cond: COND_ALWAYS,  target: STEP_EMIT};
         default:    w = '{op: OP_NOP,     cond: COND_ALWAYS,  target: STEP_WAIT};
      endcase
      return w;
   endfunction

   // year is years since 1900; the only century years in range are 1900, 2000, 2100
   function automatic logic is_leap(input logic [7:0] year);
      return (year[1:0] == 2'd0) && (year != 8'd0) && (year != 8'd200);
   endfunction

   function automatic logic [4:0] days_in(input logic [3:0] month, input logic [7:0] year);
      logic [4:0] d;
      case (month)
         4'd1:                      d = is_leap(year) ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
         default:                   d = 5'd31;
      endcase
      return d;
   endfunction

   // 8 == 1 (mod 7): fold octal digits twice, then one conditional subtract
   function automatic logic [2:0] mod7(input logic [9:0] x);
      logic [4:0] s;
      logic [3:0] t;
      s = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[9]);
      t = 4'(s[2:0]) + 4'(s[4:3]);
      return (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
   endfunction

endpackage

### rtl/calendar_date_advance_core.sv
// Calendar date advance core: keeps the stored date and rolls it forward from
// the RTC day count. Depends on cda_pkg (microcode ROM and calendar helpers).
//
// Sequence: a load passes DELTA, LOAD and EMIT; a read passes DELTA, the ROLL
// loop (one ROLL step per month crossed, plus the step that finds the day fits)
// and EMIT. rsp_tvalid is set from EMIT once the output register is free. A new
// transaction is taken only in the wait step, after EMIT and BACK; a finished
// result waits in the output register while the next transaction is taken.
// Reset (synchronous, active high) clears the stored date to all zeros and empties
// the output register.
`timescale 1ns / 1ps

module calendar_date_advance_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // day_count[8:0], tod_hours[13:9], tod_minutes[19:14], tod_seconds[25:20],
   // load_year[33:26], load_month[37:34], load_mday[42:38], load_yday[51:43],
   // load_wday[54:52], zero[55]
   input  logic [55:0] req_tdata,
   // kind[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_year[7:0], out_month[11:8], out_mday[16:12], out_yday[25:17],
   // out_wday[28:26], out_hours[33:29], out_minutes[39:34], out_seconds[45:40],
   // rewrite_days[46], new_days[55:47]
   output logic [55:0] rsp_tdata
);
   import cda_pkg::*;

   logic [2:0]  pc_ff, pc_in;
   logic        kind_ff;
   logic [55:0] req_data_ff;
   logic [7:0]  year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [9:0]  mday_ff, mday_in;
   logic [8:0]  yday_ff, yday_in;
   logic [2:0]  wday_ff, wday_in;
   logic        rewrite_ff, rewrite_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [55:0] rsp_data_ff, rsp_data_in;

   uword_type   uw;
   logic        req_fire, slot_free, fit, cond_true, emit_fire;
   logic [8:0]  day_count, delta, ylen;
   logic [4:0]  dim;
   logic [3:0]  ld_month;

   assign uw         = ucode_rom(pc_ff);
   assign req_tready = (pc_ff == STEP_WAIT);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign emit_fire  = (uw.op == OP_EMIT) && slot_free;

   assign day_count = req_data_ff[8:0];
   assign delta     = (day_count >= yday_ff) ? (day_count - yday_ff) : 9'd0;
   assign dim       = days_in(month_ff, year_ff);
   assign fit       = (mday_ff <= {5'd0, dim});
   assign ylen      = is_leap(year_ff) ? LEAP_YEAR_DAYS : YEAR_DAYS;
   assign ld_month  = (req_data_ff[37:34] > LAST_MONTH) ? LAST_MONTH : req_data_ff[37:34];

   always_comb begin
      case (uw.cond)
         COND_NEXT:    cond_true = 1'b0;
         COND_ALWAYS:  cond_true = 1'b1;
         COND_IDLE:    cond_true = !req_fire;
         COND_KIND:    cond_true = kind_ff;
         COND_NOT_FIT: cond_true = !fit;
         COND_BUSY:    cond_true = !slot_free;
         default:      cond_true = 1'b1;
      endcase
      pc_in = cond_true ? uw.target : 3'(pc_ff + 3'd1);
   end

   always_comb begin
      year_in      = year_ff;
      month_in     = month_ff;
      mday_in      = mday_ff;
      yday_in      = yday_ff;
      wday_in      = wday_ff;
      rewrite_in   = rewrite_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (uw.op)
         OP_DELTA: begin
            if (!kind_ff) begin
               mday_in    = {5'd0, mday_ff[4:0]} + {1'b0, delta};
               yday_in    = (day_count >= yday_ff) ? day_count : yday_ff;
               wday_in    = mod7({7'd0, wday_ff} + {1'b0, delta});
               rewrite_in = 1'b0;
            end
         end
         OP_ROLL: begin
            if (!fit) begin
               mday_in = mday_ff - {5'd0, dim};
               if (month_ff >= LAST_MONTH) begin
                  month_in   = 4'd0;
                  yday_in    = (yday_ff >= ylen) ? (yday_ff - ylen) : 9'd0;
                  year_in    = year_ff + 8'd1;
                  rewrite_in = 1'b1;
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end
         end
         OP_LOAD: begin
            year_in    = req_data_ff[33:26];
            month_in   = ld_month;
            mday_in    = {5'd0, req_data_ff[42:38]};
            yday_in    = req_data_ff[51:43];
            wday_in    = req_data_ff[54:52];
            rewrite_in = 1'b0;
         end
         OP_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(rewrite_ff ? yday_ff : 9'd0), rewrite_ff,
                               req_data_ff[25:9], wday_ff, yday_ff, mday_ff[4:0],
                               month_ff, year_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_WAIT;
         year_ff      <= '0;
         month_ff     <= '0;
         mday_ff      <= '0;
         yday_ff      <= '0;
         wday_ff      <= '0;
         rewrite_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         year_ff      <= year_in;
         month_ff     <= month_in;
         mday_ff      <= mday_in;
         yday_ff      <= yday_in;
         wday_ff      <= wday_in;
         rewrite_ff   <= rewrite_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_data_ff <= req_tdata;
         kind_ff     <= req_tuser;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // month counter never leaves 0..11
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      month_ff <= LAST_MONTH)
      else $error("month out of range");

   // an accepted transaction always starts at the delta step
   a_dispatch: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> pc_ff == STEP_DELTA)
      else $error("sequencer did not dispatch");

   // year rollover flag only rises in the roll step
   a_rewrite_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rewrite_ff) |-> $past(pc_ff) == STEP_ROLL)
      else $error("rewrite flag set outside roll step");

   // new day count is zero unless a rewrite is requested
   a_new_days: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[46] |-> rsp_data_ff[55:47] == 9'd0)
      else $error("new_days without rewrite");

   // the roll loop is left only when the day of month fits the month
   a_roll_exit: assert property (@(posedge clock) disable iff (reset)
      pc_ff == STEP_ROLL && pc_in == STEP_EMIT |-> mday_ff <= {5'd0, dim})
      else $error("roll loop left early");

endmodule

### bench/calendar_date_advance_core_tb.sv
// Testbench for calendar_date_advance_core: directed and random date loads and RTC reads,
// checked against an in-bench calendar predictor. Depends on cda_pkg and the core RTL.
`timescale 1ns / 1ps

module calendar_date_advance_core_tb;

   import cda_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned MAX_YDAY = 511;

   typedef enum logic {
      KIND_READ = 1'b0,
      KIND_LOAD = 1'b1
   } item_kind_type;

   typedef struct {
      item_kind_type kind;
      logic [8:0] day_count;
      logic [4:0] tod_hours;
      logic [5:0] tod_minutes;
      logic [5:0] tod_seconds;
      logic [7:0] load_year;
      logic [3:0] load_month;
      logic [4:0] load_mday;
      logic [8:0] load_yday;
      logic [2:0] load_wday;
   } date_request_type;

   typedef struct {
      logic [7:0] year;
      logic [3:0] month;
      logic [4:0] mday;
      logic [8:0] yday;
      logic [2:0] wday;
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic       rewrite_days;
      logic [8:0] new_days;
   } date_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;

   // calendar state as the predictor sees it after the last accepted transaction
   logic [7:0] cal_year;
   logic [3:0] cal_month;
   logic [4:0] cal_mday;
   logic [8:0] cal_yday;
   logic [2:0] cal_wday;

   date_result_type predicted_dates[$];
   bit           gaps_on;
   bit           stall_on;
   int unsigned  hold_cycles;
   int unsigned  mismatches;
   int unsigned  cycle_count;
   int unsigned  read_count;
   int unsigned  load_count;
   int unsigned  rollover_count;
   int unsigned  checked_count;

   calendar_date_advance_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
                  cycle_count, predicted_dates.size());
         $display("** calendar_date_advance_core: FAILED **");
         $finish;
      end
   end

   // ---------------- calendar predictor ----------------

   function automatic bit leap_year(input logic [7:0] year);
      int unsigned y;
      y = 1900 + year;
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned month_days(input logic [3:0] month, input logic [7:0] year);
      case (month)
         4'd1:                    return leap_year(year) ? 29 : 28;
         4'd3, 4'd5, 4'd8, 4'd10: return 30;
         default:                 return 31;
      endcase
   endfunction

   function automatic date_result_type advance_calendar(input date_request_type it);
      date_result_type r;
      int unsigned  delta;
      int unsigned  yday;
      int unsigned  mday;
      int unsigned  ylen;
      logic [3:0]   month;
      logic [7:0]   year;
      r.rewrite_days = 1'b0;
      r.new_days = '0;
      if (it.kind == KIND_LOAD) begin
         cal_year = it.load_year;
         cal_month = (it.load_month > LAST_MONTH) ? LAST_MONTH : it.load_month;
         cal_mday = it.load_mday;
         cal_yday = it.load_yday;
         cal_wday = it.load_wday;
      end else begin
         // a day count behind the stored day of year means no time has passed
         delta = (it.day_count >= cal_yday) ? it.day_count - cal_yday : 0;
         yday = cal_yday + delta;
         mday = cal_mday + delta;
         month = cal_month;
         year = cal_year;
         cal_wday = 3'((cal_wday + delta) % 7);
         while (mday > month_days(month, year)) begin
            mday -= month_days(month, year);
            month++;
            if (month >= 4'd12) begin
               ylen = leap_year(year) ? 366 : 365;
               month -= 4'd12;
               yday = (yday >= ylen) ? yday - ylen : 0;
               year++;
               r.rewrite_days = 1'b1;
            end
         end
         if (yday > MAX_YDAY)
            yday = MAX_YDAY;
         cal_year = year;
         cal_month = month;
         cal_mday = 5'(mday);
         cal_yday = 9'(yday);
         if (r.rewrite_days)
            r.new_days = 9'(yday);
      end
      r.year = cal_year;
      r.month = cal_month;
      r.mday = cal_mday;
      r.yday = cal_yday;
      r.wday = cal_wday;
      r.hours = it.tod_hours;
      r.minutes = it.tod_minutes;
      r.seconds = it.tod_seconds;
      return r;
   endfunction

   function automatic int unsigned day_of_year(input logic [3:0] month, input logic [4:0] mday,
                                               input logic [7:0] year);
      int unsigned total;
      total = mday - 1;
      for (int m = 0; m < month; m++)
         total += month_days(4'(m), year);
      return total;
   endfunction

   // ---------------- sender ----------------

   task automatic send_item(input date_request_type it);
      date_result_type r;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.kind;
      req_tdata <= {1'b0, it.load_wday, it.load_yday, it.load_mday, it.load_month,
                    it.load_year, it.tod_seconds, it.tod_minutes, it.tod_hours, it.day_count};
      do
         @(posedge clock);
      while (!req_tready);
      r = advance_calendar(it);
      predicted_dates.push_back(r);
      if (it.kind == KIND_LOAD)
         load_count++;
      else
         read_count++;
      if (r.rewrite_days)
         rollover_count++;
   endtask

   function automatic date_request_type random_fields();
      date_request_type it;
      it.kind = KIND_READ;
      it.day_count = 9'($urandom);
      it.tod_hours = 5'($urandom_range(0, 23));
      it.tod_minutes = 6'($urandom_range(0, 59));
      it.tod_seconds = 6'($urandom_range(0, 59));
      it.load_year = 8'($urandom);
      it.load_month = 4'($urandom);
      it.load_mday = 5'($urandom);
      it.load_yday = 9'($urandom);
      it.load_wday = 3'($urandom);
      return it;
   endfunction

   task automatic send_load(input int unsigned year, input int unsigned month,
                            input int unsigned mday, input int unsigned yday,
                            input int unsigned wday);
      date_request_type it;
      it = random_fields();
      it.kind = KIND_LOAD;
      it.load_year = 8'(year);
      it.load_month = 4'(month);
      it.load_mday = 5'(mday);
      it.load_yday = 9'(yday);
      it.load_wday = 3'(wday);
      send_item(it);
   endtask

   task automatic send_read(input int unsigned days);
      date_request_type it;
      it = random_fields();
      it.day_count = 9'(days);
      send_item(it);
   endtask

   // mostly valid dates and plausible RTC readings; a share of odd loads and stray counts
   function automatic date_request_type random_request();
      date_request_type it;
      int unsigned   pick;
      int unsigned   step;
      it = random_fields();
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
         it.kind = KIND_LOAD;
         if ($urandom_range(0, 3) == 0) begin
            it.load_month = LAST_MONTH;
            it.load_mday = 5'($urandom_range(20, 31));
         end else begin
            it.load_month = 4'($urandom_range(0, 11));
            it.load_mday = 5'($urandom_range(1, month_days(it.load_month, it.load_year)));
         end
         it.load_yday = 9'(day_of_year(it.load_month, it.load_mday, it.load_year));
         it.load_wday = 3'($urandom_range(0, 6));
      end else if (pick < 24) begin
         it.kind = KIND_LOAD;
      end else if (pick < 94) begin
         pick = $urandom_range(0, 99);
         if (pick < 60)
            step = $urandom_range(0, 3);
         else if (pick < 85)
            step = $urandom_range(0, 45);
         else
            step = $urandom_range(0, MAX_YDAY);
         it.day_count = 9'((cal_yday + step > MAX_YDAY) ? MAX_YDAY : cal_yday + step);
      end
      return it;
   endfunction

   // ---------------- receiver and checker ----------------

   initial begin : rsp_side
      int unsigned span;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            span = hold_cycles;
            hold_cycles = 0;
         end else if (stall_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            span = $urandom_range(1, 17);
         end else begin
            rsp_tready <= 1'b1;
            span = $urandom_range(1, 12);
         end
         repeat (span) @(posedge clock);
      end
   end

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      date_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (predicted_dates.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual data %h", $time,
                     rsp_tdata);
            mismatches++;
         end else begin
            want = predicted_dates.pop_front();
            checked_count++;
            compare_field("year", want.year, rsp_tdata[7:0]);
            compare_field("month", want.month, rsp_tdata[11:8]);
            compare_field("mday", want.mday, rsp_tdata[16:12]);
            compare_field("yday", want.yday, rsp_tdata[25:17]);
            compare_field("wday", want.wday, rsp_tdata[28:26]);
            compare_field("hours", want.hours, rsp_tdata[33:29]);
            compare_field("minutes", want.minutes, rsp_tdata[39:34]);
            compare_field("seconds", want.seconds, rsp_tdata[45:40]);
            compare_field("rewrite_days", want.rewrite_days, rsp_tdata[46]);
            compare_field("new_days", want.new_days, rsp_tdata[55:47]);
         end
      end
   end

   // ---------------- tests ----------------

   task automatic test_directed();
      date_request_type it;
      send_read(0);                        // untouched reset state, nothing moves
      send_read(511);                      // largest jump from reset, crosses 1900
      // time of day at both ends
      it = random_fields();
      it.kind = KIND_LOAD;
      it.tod_hours = 5'd23;
      it.tod_minutes = 6'd59;
      it.tod_seconds = 6'd59;
      it.load_year = 8'd100;
      it.load_month = 4'd1;
      it.load_mday = 5'd28;
      it.load_yday = 9'd58;
      it.load_wday = 3'd1;
      send_item(it);
      send_read(59);                       // Feb 29 in 2000
      it = random_fields();
      it.day_count = 9'd60;
      it.tod_hours = '0;
      it.tod_minutes = '0;
      it.tod_seconds = '0;
      send_item(it);                       // Mar 1
      send_load(0, 1, 28, 58, 3);          // 1900 is not leap
      send_read(59);
      send_load(200, 1, 28, 58, 0);        // 2100 is not leap
      send_read(59);
      send_load(255, 11, 31, 364, 6);      // year 255 wraps to 0
      send_read(365);
      send_load(20, 6, 19, 200, 2);        // RTC count behind the stored day
      send_read(10);
      send_load(10, 11, 31, 0, 5);         // two year rollovers, day of year floors at zero
      send_read(511);
      send_load(50, 15, 10, 100, 4);       // month above range
      send_read(120);
      send_load(60, 12, 0, 511, 7);        // day 0, weekday 7, day of year past the end
      send_read(511);
      send_read(3);
      send_load(255, 15, 31, 511, 7);      // all load fields at their top
      send_load(0, 0, 0, 0, 0);
      send_read(1);
   endtask

   task automatic test_random(input int unsigned count);
      repeat (count)
         send_item(random_request());
   endtask

   // receiver blocks for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      bit saved_gaps;
      saved_gaps = gaps_on;
      gaps_on = 0;
      hold_cycles = 300;
      repeat (40)
         send_item(random_request());
      gaps_on = saved_gaps;
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= 1'b0;
      req_tdata <= '0;
      cal_year = '0;
      cal_month = '0;
      cal_mday = '0;
      cal_yday = '0;
      cal_wday = '0;
      gaps_on = 1;
      stall_on = 1;
      hold_cycles = 0;
      mismatches = 0;
      cycle_count = 0;
      read_count = 0;
      load_count = 0;
      rollover_count = 0;
      checked_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(1050);
      test_backpressure();
      gaps_on = 0;
      stall_on = 0;
      test_random(240);
      req_tvalid <= 1'b0;

      while (predicted_dates.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d transactions: %0d RTC reads, %0d date loads, %0d year rollovers.",
               read_count + load_count, read_count, load_count, rollover_count);
      $display("Checked %0d results, %0d field mismatches.", checked_count, mismatches);
      if (mismatches == 0)
         $display("** calendar_date_advance_core: PASSED **");
      else
         $display("** calendar_date_advance_core: FAILED **");
      $finish;
   end

endmodule

### filelist.f
rtl/cda_pkg.sv
rtl/calendar_date_advance_core.sv
bench/calendar_date_advance_core_tb.sv
